// ===== hw/rtl/calendar_date_add_days_defines.svh =====
// ----------------------------------------------------------------------------
// Calendar date adder assertion macros
// Shared macros for the concurrent checks of the date adder.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_ADD_DAYS_DEFINES_SVH
`define CALENDAR_DATE_ADD_DAYS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dad_pkg.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder package
// Microcode types, step addresses, calendar constants and helper functions.
// ----------------------------------------------------------------------------
package dad_pkg;

  localparam int YEAR_W = 16;
  localparam int RES_W  = 9;
  localparam int STEP_W = 3;

  localparam logic [3:0]       MONTH_JAN = 4'd1;
  localparam logic [3:0]       MONTH_DEC = 4'd12;
  localparam logic [RES_W-1:0] CYCLE_LEN = 9'd400;
  localparam logic [RES_W-1:0] CENTURY   = 9'd100;
  localparam logic [RES_W-1:0] CENTURY2  = 9'd200;
  localparam logic [RES_W-1:0] CENTURY3  = 9'd300;
  localparam logic [4:0]       FEB_LEAP  = 5'd29;
  localparam logic [4:0]       FEB_PLAIN = 5'd28;

  // Reciprocal of 25 scaled by 2**15, exact for dividends below 1024.
  localparam logic [10:0]      RECIP_25  = 11'd1311;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_IDLE  = 3'd0;
  localparam step_t ST_CHECK = 3'd1;
  localparam step_t ST_MOD   = 3'd2;
  localparam step_t ST_WALK  = 3'd3;
  localparam step_t ST_EMIT  = 3'd4;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_NOP,
    OP_MOD,
    OP_WALK,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    C_IN_VALID,
    C_ERR,
    C_WALK_DONE,
    C_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t tgt_t;
    step_t tgt_f;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic err;
    logic walk_done;
  } stat_t;

  function automatic logic is_leap(logic [RES_W-1:0] r);
    return (r[1:0] == 2'b00) && (r != CENTURY) && (r != CENTURY2) && (r != CENTURY3);
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                len = leap ? FEB_LEAP : FEB_PLAIN;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:             len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== hw/rtl/dad_ctrl.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder sequencer
// Step counter with a read-only microprogram and conditional jumps.
// ----------------------------------------------------------------------------
module dad_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dad_pkg::stat_t stat_i,
  output dad_pkg::op_e  op_o
);
  import dad_pkg::*;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    case (s)
      ST_IDLE:  w = '{op: OP_LOAD, cond: C_IN_VALID,  tgt_t: ST_CHECK, tgt_f: ST_IDLE};
      ST_CHECK: w = '{op: OP_NOP,  cond: C_ERR,       tgt_t: ST_EMIT,  tgt_f: ST_MOD};
      ST_MOD:   w = '{op: OP_MOD,  cond: C_ERR,       tgt_t: ST_WALK,  tgt_f: ST_WALK};
      ST_WALK:  w = '{op: OP_WALK, cond: C_WALK_DONE, tgt_t: ST_EMIT,  tgt_f: ST_WALK};
      ST_EMIT:  w = '{op: OP_EMIT, cond: C_OUT_FREE,  tgt_t: ST_IDLE,  tgt_f: ST_EMIT};
      default:  w = '{op: OP_NOP,  cond: C_ERR,       tgt_t: ST_IDLE,  tgt_f: ST_IDLE};
    endcase
    return w;
  endfunction

  step_t  upc_q, upc_d;
  uword_t word;
  logic   hit;

  always_comb begin
    word = ucode(upc_q);
    case (word.cond)
      C_IN_VALID:  hit = stat_i.in_valid;
      C_ERR:       hit = stat_i.err;
      C_WALK_DONE: hit = stat_i.walk_done;
      C_OUT_FREE:  hit = stat_i.out_free;
      default:     hit = 1'b0;
    endcase
    upc_d = hit ? word.tgt_t : word.tgt_f;
    op_o  = word.op;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// ===== hw/rtl/dad_dp.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder datapath
// Day, month and year registers, year residue unit and output register.
// ----------------------------------------------------------------------------
module dad_dp #(
  parameter int MAX_YEAR     = 9999,
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  dad_pkg::op_e                   op_i,
  output dad_pkg::stat_t                 stat_o,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [4:0]                     start_day_i,
  input  logic [3:0]                     start_month_i,
  input  logic [13:0]                    start_year_i,
  input  logic signed [OFFSET_WIDTH-1:0] day_offset_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [4:0]                     result_day_o,
  output logic [3:0]                     result_month_o,
  output logic [13:0]                    result_year_o,
  output logic                           range_error_o
);
  import dad_pkg::*;

  localparam int DayW = OFFSET_WIDTH + 2;
  localparam logic [YEAR_W-1:0] YearMax = YEAR_W'(MAX_YEAR);
  localparam logic [YEAR_W-1:0] YearMin = YEAR_W'(1);

  logic signed [DayW-1:0] day_q, day_d;
  logic [3:0]             m_q, m_d;
  logic [YEAR_W-1:0]      y_q, y_d;
  logic [RES_W-1:0]       r_q, r_d;
  logic                   err_q, err_d;
  logic [4:0]             d0_q;
  logic [3:0]             m0_q;
  logic [13:0]            y0_q;
  logic                   out_valid_q, out_valid_d;
  logic [4:0]             res_day_q;
  logic [3:0]             res_month_q;
  logic [13:0]            res_year_q;
  logic                   res_err_q;

  logic                   accept, bad_in, emit, out_free;
  logic [4:0]             len_cur, len_prev;
  logic                   day_gt, day_lt1;
  logic [9:0]             y_hi;
  logic [20:0]            quo_prod;
  logic [5:0]             quo_25;
  logic [9:0]             quo_back;
  logic [9:0]             rem_25;

  assign in_stall_o = (op_i != OP_LOAD);
  assign accept     = in_valid_i && (op_i == OP_LOAD);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = (op_i == OP_EMIT) && out_free;

  assign bad_in = (start_month_i == 4'd0) || (start_month_i > MONTH_DEC) ||
                  (start_year_i == 14'd0) || (YEAR_W'(start_year_i) > YearMax);

  assign len_cur  = month_len(m_q, is_leap(r_q));
  assign len_prev = month_len(m_q - 4'd1, is_leap(r_q));
  assign day_gt   = day_q > signed'(DayW'(len_cur));
  assign day_lt1  = day_q[DayW-1] || (day_q == '0);

  // The year modulo 400 is 16 * ((year / 16) mod 25) + (year mod 16).
  assign y_hi     = y_q[13:4];
  assign quo_prod = 21'(y_hi) * 21'(RECIP_25);
  assign quo_25   = quo_prod[20:15];
  assign quo_back = {quo_25, 4'b0000} + {1'b0, quo_25, 3'b000} + {4'b0000, quo_25};
  assign rem_25   = y_hi - quo_back;

  assign stat_o.in_valid  = in_valid_i;
  assign stat_o.out_free  = out_free;
  assign stat_o.err       = err_q;
  assign stat_o.walk_done = err_q || (!day_gt && !day_lt1);

  always_comb begin
    day_d = day_q;
    m_d   = m_q;
    y_d   = y_q;
    r_d   = r_q;
    err_d = err_q;
    case (op_i)
      OP_LOAD: begin
        if (accept) begin
          day_d = DayW'(signed'({1'b0, start_day_i})) + DayW'(day_offset_i);
          m_d   = start_month_i;
          y_d   = YEAR_W'(start_year_i);
          r_d   = '0;
          err_d = bad_in;
        end
      end
      OP_MOD: begin
        r_d = {rem_25[4:0], y_q[3:0]};
      end
      OP_WALK: begin
        if (!err_q && day_gt) begin
          day_d = day_q - signed'(DayW'(len_cur));
          if (m_q == MONTH_DEC) begin
            if (y_q >= YearMax) begin
              err_d = 1'b1;
            end else begin
              m_d = MONTH_JAN;
              y_d = y_q + YEAR_W'(1);
              r_d = (r_q == CYCLE_LEN - RES_W'(1)) ? '0 : r_q + RES_W'(1);
            end
          end else begin
            m_d = m_q + 4'd1;
          end
        end else if (!err_q && day_lt1) begin
          if (m_q == MONTH_JAN) begin
            if (y_q <= YearMin) begin
              err_d = 1'b1;
            end else begin
              m_d   = MONTH_DEC;
              y_d   = y_q - YEAR_W'(1);
              r_d   = (r_q == '0) ? CYCLE_LEN - RES_W'(1) : r_q - RES_W'(1);
              day_d = day_q + signed'(DayW'(month_len(MONTH_DEC, 1'b0)));
            end
          end else begin
            m_d   = m_q - 4'd1;
            day_d = day_q + signed'(DayW'(len_prev));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    day_q <= day_d;
    m_q   <= m_d;
    y_q   <= y_d;
    r_q   <= r_d;
    if (accept) begin
      d0_q <= start_day_i;
      m0_q <= start_month_i;
      y0_q <= start_year_i;
    end
    if (emit) begin
      res_err_q <= err_q;
      if (err_q) begin
        res_day_q   <= d0_q;
        res_month_q <= m0_q;
        res_year_q  <= y0_q;
      end else begin
        res_day_q   <= day_q[4:0];
        res_month_q <= m_q;
        res_year_q  <= y_q[13:0];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_day_o   = res_day_q;
  assign result_month_o = res_month_q;
  assign result_year_o  = res_year_q;
  assign range_error_o  = res_err_q;

endmodule

// ===== hw/rtl/calendar_date_add_days.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder
// Adds a signed day count to a Gregorian date and returns the normalized date.
// The input channel takes one transaction (day, month, year, offset) when
// in_valid_i is high and in_stall_o is low; the block then stalls its input
// until the result is written into the output register. After acceptance a
// transaction passes the check step, the year residue modulo 400 step, the
// month walk step, which moves one month at a time until the day fits, and
// the emit step, which writes the result once the output register is free.
// The length of the month walk sets how long a transaction takes. A date
// with a bad month or year skips the residue and the walk, and a walk leaving
// 1..MAX_YEAR ends there; both return the input date with range_error_o set.
// The output register holds its transaction while out_stall_i is high, and a
// new input is accepted while a result still waits there. Reset empties the
// output register and returns the sequencer to its idle step.
// ----------------------------------------------------------------------------
module calendar_date_add_days #(
  parameter int MAX_YEAR     = 9999,
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [4:0]                     start_day_i,
  input  logic [3:0]                     start_month_i,
  input  logic [13:0]                    start_year_i,
  input  logic signed [OFFSET_WIDTH-1:0] day_offset_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [4:0]                     result_day_o,
  output logic [3:0]                     result_month_o,
  output logic [13:0]                    result_year_o,
  output logic                           range_error_o
);
  import dad_pkg::*;

  op_e   op;
  stat_t stat;

  dad_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .op_o   (op)
  );

  dad_dp #(
    .MAX_YEAR     (MAX_YEAR),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (op),
    .stat_o         (stat),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .day_offset_i   (day_offset_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .range_error_o  (range_error_o)
  );

endmodule

// ===== hw/rtl/dad_checker.sv =====
// ----------------------------------------------------------------------------
// Calendar date adder checker
// Port-level checks of the date adder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "calendar_date_add_days_defines.svh"

module dad_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [4:0]  result_day_o,
  input logic [3:0]  result_month_o,
  input logic [13:0] result_year_o,
  input logic        range_error_o
);

  `DAD_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(result_day_o) && $stable(result_month_o) && $stable(result_year_o) && $stable(range_error_o), "stalled result changed")

  `DAD_ASSERT_NOW(a_good_date, out_valid_o && !range_error_o, (result_month_o != 4'd0) && (result_month_o <= 4'd12) && (result_day_o != 5'd0) && (result_year_o != 14'd0), "result date is not normalized")

  `DAD_ASSERT_NEXT(a_one_inflight, in_valid_i && !in_stall_o, in_stall_o, "second transaction taken while one is in work")

  `DAD_ASSERT_NEXT(a_no_early_result, in_valid_i && !in_stall_o, !$rose(out_valid_o), "result appeared one cycle after acceptance")

endmodule

bind calendar_date_add_days dad_checker u_dad_checker (.*);
